@@ design/lru_keyed_object_cache_unit_macros.svh @@
// Assertion macros for the cache checker.
`ifndef LRU_KEYED_OBJECT_CACHE_UNIT_MACROS_SVH
`define LRU_KEYED_OBJECT_CACHE_UNIT_MACROS_SVH

// Clocked check, off while reset is held.
`define LKOC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs through reset.
`define LKOC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/lkoc_pkg.sv @@
package lkoc_pkg;

    // default sizes
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_HANDLE_BITS = 32;

    // field widths fixed by the port formats
    localparam int OP_W     = 2;
    localparam int REASON_W = 2;
    localparam int CAP_W    = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request operations
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // why a handle was handed back
    localparam logic [REASON_W-1:0] FREED_NONE     = 2'd0;
    localparam logic [REASON_W-1:0] FREED_REPLACED = 2'd1;
    localparam logic [REASON_W-1:0] FREED_EVICTED  = 2'd2;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;   // compare against the incoming key
        logic shift;     // take the neighbor's entry
        logic clear;     // drop the entry
    } cell_ctrl_t;

endpackage

@@ design/lkoc_cell.sv @@
// One recency slot: holds an entry, matches keys, and takes its
// more-recent neighbor's entry when the row shifts.
module lkoc_cell #(
    parameter int KEY_BITS    = lkoc_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = lkoc_pkg::DEF_HANDLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lkoc_pkg::cell_ctrl_t   ctrl,
    input  logic [KEY_BITS-1:0]    cmp_key,
    input  logic                   prev_valid,
    input  logic [KEY_BITS-1:0]    prev_key,
    input  logic [HANDLE_BITS-1:0] prev_handle,
    output logic                   valid,
    output logic [KEY_BITS-1:0]    key,
    output logic [HANDLE_BITS-1:0] handle,
    output logic                   match
);

    logic                   valid_reg;
    logic                   match_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // valid and match flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                valid_reg <= 1'b0;
            end else if (ctrl.shift) begin
                valid_reg <= prev_valid;
            end
            if (ctrl.capture) begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    // entry payload
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            key_reg    <= prev_key;
            handle_reg <= prev_handle;
        end
    end

    assign valid  = valid_reg;
    assign key    = key_reg;
    assign handle = handle_reg;
    assign match  = match_reg;

endmodule

@@ design/lru_keyed_object_cache_unit.sv @@
// Result path: an accepted request is registered along with the cell match flags; in the update
//   state the result is loaded into the output register, where it is held until it is taken.
// Flow: a request runs a match step and then a shift step of the recency-ordered cell row;
//   no new request is taken before then, nor while an untaken result holds the output register.
// Reset (aresetn low, synchronous): all entries invalid, count zero, capacity 16,
//   output empty. No clearing pass; the cache takes requests right after reset.
module lru_keyed_object_cache_unit #(
    parameter int MAX_ENTRIES = lkoc_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lkoc_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = lkoc_pkg::DEF_HANDLE_BITS,
    localparam int S_DATA_W   = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * HANDLE_BITS + KEY_BITS + 7) / 8) * 8,
    localparam int M_USER_W   = 1 + lkoc_pkg::REASON_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_DATA_W-1:0]        s_tdata,   // key, handle, zero pad
    input  logic [lkoc_pkg::OP_W-1:0]  s_tuser,   // operation
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // found_handle, freed_key, freed_handle, pad
    output logic [M_USER_W-1:0]        m_tuser,   // hit, freed_reason
    // capacity register
    input  logic                       cfg_wr_en,
    input  logic [lkoc_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CW > lkoc_pkg::CAP_W) ? CW : lkoc_pkg::CAP_W;

    lkoc_pkg::state_t state_reg, state_next;

    logic [lkoc_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]              count_reg, count_next;

    logic [lkoc_pkg::OP_W-1:0]  req_op_reg;
    logic [KEY_BITS-1:0]        req_key_reg;
    logic [HANDLE_BITS-1:0]     req_handle_reg;

    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0]        m_tuser_reg, m_tuser_next;

    logic accept;
    logic upd;

    // cell row, index 0 is most recent
    lkoc_pkg::cell_ctrl_t   cell_ctrl   [MAX_ENTRIES];
    logic                   cell_valid  [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    cell_key    [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] cell_handle [MAX_ENTRIES];
    logic                   cell_match  [MAX_ENTRIES];
    logic                   cell_last   [MAX_ENTRIES];
    logic                   prev_valid  [MAX_ENTRIES];
    logic [KEY_BITS-1:0]    prev_key    [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] prev_handle [MAX_ENTRIES];

    logic                   front_valid;
    logic [HANDLE_BITS-1:0] front_handle;

    logic                   any_hit;
    logic [IW-1:0]          hit_idx;
    logic [HANDLE_BITS-1:0] hit_handle;
    logic [KEY_BITS-1:0]    evict_key;
    logic [HANDLE_BITS-1:0] evict_handle;
    logic [CMP_W-1:0]       eff_cap;
    logic                   full;
    logic                   do_hit;
    logic                   miss_insert;
    logic                   shift_en;
    logic [IW-1:0]          target;

    assign accept = s_tvalid && s_tready;
    assign upd    = (state_reg == lkoc_pkg::ST_UPDATE);

    // cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        if (i == 0) begin : g_front
            assign prev_valid[i]  = front_valid;
            assign prev_key[i]    = req_key_reg;
            assign prev_handle[i] = front_handle;
        end else begin : g_link
            assign prev_valid[i]  = cell_valid[i-1];
            assign prev_key[i]    = cell_key[i-1];
            assign prev_handle[i] = cell_handle[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_tail
            assign cell_last[i] = cell_valid[i];
        end else begin : g_body
            assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
        end

        lkoc_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl[i]),
            .cmp_key     (s_tdata[KEY_BITS-1:0]),
            .prev_valid  (prev_valid[i]),
            .prev_key    (prev_key[i]),
            .prev_handle (prev_handle[i]),
            .valid       (cell_valid[i]),
            .key         (cell_key[i]),
            .handle      (cell_handle[i]),
            .match       (cell_match[i])
        );
    end

    // hit position and the entries that can be handed back
    always_comb begin
        any_hit      = 1'b0;
        hit_idx      = '0;
        hit_handle   = '0;
        evict_key    = '0;
        evict_handle = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            any_hit      = any_hit | cell_match[i];
            hit_idx      = hit_idx | (cell_match[i] ? IW'(i) : '0);
            hit_handle   = hit_handle | (cell_match[i] ? cell_handle[i] : '0);
            evict_key    = evict_key | (cell_last[i] ? cell_key[i] : '0);
            evict_handle = evict_handle | (cell_last[i] ? cell_handle[i] : '0);
        end
    end

    // effective capacity, zero acts as one, clamp at the row length
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    // update decision: which entry moves to the front
    always_comb begin
        full        = CMP_W'(count_reg) >= eff_cap;
        do_hit      = any_hit && ((req_op_reg == lkoc_pkg::OP_LOOKUP) ||
                                  (req_op_reg == lkoc_pkg::OP_INSERT));
        miss_insert = !any_hit && (req_op_reg == lkoc_pkg::OP_INSERT);
        shift_en    = do_hit || miss_insert;
        front_valid = 1'b1;
        front_handle = (req_op_reg == lkoc_pkg::OP_LOOKUP) ? hit_handle : req_handle_reg;
        if (do_hit) begin
            target = hit_idx;
        end else if (full) begin
            target = IW'(count_reg - CW'(1));
        end else begin
            target = IW'(count_reg);
        end
    end

    // cell controls
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            cell_ctrl[i].capture = accept;
            cell_ctrl[i].clear   = upd && (req_op_reg == lkoc_pkg::OP_CLEAR);
            cell_ctrl[i].shift   = upd && shift_en && (IW'(i) <= target);
        end
    end

    // entry count and result
    always_comb begin
        logic [HANDLE_BITS-1:0]         found;
        logic [lkoc_pkg::REASON_W-1:0]  reason;
        logic [KEY_BITS-1:0]            fkey;
        logic [HANDLE_BITS-1:0]         fhandle;
        count_next = count_reg;
        found      = '0;
        reason     = lkoc_pkg::FREED_NONE;
        fkey       = '0;
        fhandle    = '0;
        if (req_op_reg == lkoc_pkg::OP_CLEAR) begin
            count_next = '0;
        end else if (miss_insert && !full) begin
            count_next = count_reg + CW'(1);
        end
        if (do_hit && (req_op_reg == lkoc_pkg::OP_LOOKUP)) begin
            found = hit_handle;
        end
        if (do_hit && (req_op_reg == lkoc_pkg::OP_INSERT)) begin
            reason  = lkoc_pkg::FREED_REPLACED;
            fkey    = req_key_reg;
            fhandle = hit_handle;
        end else if (miss_insert && full) begin
            reason  = lkoc_pkg::FREED_EVICTED;
            fkey    = evict_key;
            fhandle = evict_handle;
        end
        m_tdata_next = M_DATA_W'({fhandle, fkey, found});
        m_tuser_next = {reason, do_hit};
    end

    // sequencer next state and ready
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            lkoc_pkg::ST_IDLE: begin
                s_tready = !m_tvalid_reg || m_tready;
                if (s_tvalid && s_tready) begin
                    state_next = lkoc_pkg::ST_UPDATE;
                end
            end
            lkoc_pkg::ST_UPDATE: begin
                state_next = lkoc_pkg::ST_IDLE;
            end
            default: begin
                state_next = lkoc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lkoc_pkg::ST_IDLE;
            cap_reg      <= lkoc_pkg::CAP_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (upd) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_op_reg     <= s_tuser;
            req_key_reg    <= s_tdata[KEY_BITS-1:0];
            req_handle_reg <= s_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];
        end
        if (upd) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ design/lkoc_checker.sv @@
`include "lru_keyed_object_cache_unit_macros.svh"

// Port-level checks on the cache.
module lkoc_checker #(
    parameter int KEY_BITS    = lkoc_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = lkoc_pkg::DEF_HANDLE_BITS,
    localparam int S_DATA_W   = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * HANDLE_BITS + KEY_BITS + 7) / 8) * 8,
    localparam int M_USER_W   = 1 + lkoc_pkg::REASON_W
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [S_DATA_W-1:0]        s_tdata,
    input logic [lkoc_pkg::OP_W-1:0]  s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [M_DATA_W-1:0]        m_tdata,
    input logic [M_USER_W-1:0]        m_tuser,
    input logic                       cfg_wr_en,
    input logic [lkoc_pkg::CAP_W-1:0] cfg_wr_data
);

    // one request at a time: no accept right after an accept
    `LKOC_ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // every request yields a result, registered after its update state
    `LKOC_ASSERT_CLK(a_result_follows, s_tvalid && s_tready |=> ##1 m_tvalid, "result missing after request")

    // a stalled result holds
    `LKOC_ASSERT_CLK(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // an eviction comes only from a miss, and a miss finds no handle
    `LKOC_ASSERT_CLK(a_evict_is_miss, m_tvalid && (m_tuser[2:1] == lkoc_pkg::FREED_EVICTED) |-> !m_tuser[0] && (m_tdata[HANDLE_BITS-1:0] == '0), "eviction on a hit")

    // reset empties the output and opens the input
    `LKOC_ASSERT_RST(a_reset_state, !aresetn |=> !m_tvalid && s_tready, "bad state after reset")

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, cfg_wr_en, cfg_wr_data};

endmodule

bind lru_keyed_object_cache_unit lkoc_checker #(
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_lkoc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);
